// File: rtl/vei_pkg.sv
package vei_pkg;

  // Sizes
  localparam int unsigned MAX_VERTS   = 1024;
  localparam int unsigned MAX_ENTRIES = 4096;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VERT_W   = 10;
  localparam int unsigned POS_W    = 13;
  localparam int unsigned VALUE_W  = 13;
  localparam int unsigned VCOUNT_W = 11;
  localparam int unsigned COUNT_W  = 13;  // holds 0..MAX_ENTRIES
  localparam int unsigned SLOT_W   = 12;  // index into the entry stores
  localparam int unsigned OFF_AW   = 11;  // index into offsets / cursors
  localparam int unsigned OFF_DEPTH = MAX_VERTS + 1;
  localparam int unsigned PC_W     = 4;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(MAX_VERTS);
  localparam logic [COUNT_W-1:0]  ENTRY_FULL   = COUNT_W'(MAX_ENTRIES);

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINISH   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RD_OFF   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RD_SUPP  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VERT_W-1:0] vertex;
    logic [POS_W-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
  } out_item_t;

  // Microcode fields
  typedef enum logic [2:0] {
    OFF_NONE,   // no access
    OFF_CLR_I,  // offsets[cnt] = 0
    OFF_RD_V,   // read offsets[v]
    OFF_INC_V,  // offsets[v] = rdata + 1
    OFF_RD_I,   // read offsets[cnt]
    OFF_PFX_I   // offsets[cnt] = run
  } off_op_e;

  typedef enum logic [1:0] {
    CUR_NONE,   // no access
    CUR_PFX_I,  // cursor[cnt] = run
    CUR_RD_V,   // read cursor[v]
    CUR_INC_V   // cursor[v] = rdata + 1
  } cur_op_e;

  typedef enum logic [2:0] {
    SEQ_NEXT,       // fall through
    SEQ_LOOP_VC,    // repeat while cnt < active vertex count
    SEQ_LOOP_TOT,   // repeat while cnt + 1 < entry total
    SEQ_SKIP_EMPTY, // jump when no entries are stored
    SEQ_END         // back to idle
  } seq_op_e;

  typedef struct packed {
    logic             ev_rd;
    off_op_e          off_op;
    cur_op_e          cur_op;
    logic             sup_wr;
    logic             chk_drop;
    logic             run_add;
    logic             done;
    seq_op_e          seq;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // Step addresses of the finish program
  localparam logic [PC_W-1:0] PC_CLR      = 4'd0;
  localparam logic [PC_W-1:0] PC_CNT_SKIP = 4'd1;
  localparam logic [PC_W-1:0] PC_CNT_EV   = 4'd2;
  localparam logic [PC_W-1:0] PC_CNT_RD   = 4'd3;
  localparam logic [PC_W-1:0] PC_CNT_WR   = 4'd4;
  localparam logic [PC_W-1:0] PC_PFX_RD   = 4'd5;
  localparam logic [PC_W-1:0] PC_PFX_WR   = 4'd6;
  localparam logic [PC_W-1:0] PC_SC_SKIP  = 4'd7;
  localparam logic [PC_W-1:0] PC_SC_EV    = 4'd8;
  localparam logic [PC_W-1:0] PC_SC_RD    = 4'd9;
  localparam logic [PC_W-1:0] PC_SC_WR    = 4'd10;
  localparam logic [PC_W-1:0] PC_DONE     = 4'd11;

  localparam ucode_t UC_NOP = '{
    ev_rd:    1'b0,
    off_op:   OFF_NONE,
    cur_op:   CUR_NONE,
    sup_wr:   1'b0,
    chk_drop: 1'b0,
    run_add:  1'b0,
    done:     1'b0,
    seq:      SEQ_NEXT,
    target:   PC_CLR
  };

  // Finish program: clear, count, prefix sum, stable scatter
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = UC_NOP;
    unique case (pc)
      PC_CLR: begin
        w.off_op = OFF_CLR_I;
        w.seq    = SEQ_LOOP_VC;
        w.target = PC_CLR;
      end
      PC_CNT_SKIP: begin
        w.seq    = SEQ_SKIP_EMPTY;
        w.target = PC_PFX_RD;
      end
      PC_CNT_EV: begin
        w.ev_rd = 1'b1;
      end
      PC_CNT_RD: begin
        w.off_op   = OFF_RD_V;
        w.chk_drop = 1'b1;
      end
      PC_CNT_WR: begin
        w.off_op = OFF_INC_V;
        w.seq    = SEQ_LOOP_TOT;
        w.target = PC_CNT_EV;
      end
      PC_PFX_RD: begin
        w.off_op = OFF_RD_I;
      end
      PC_PFX_WR: begin
        w.off_op  = OFF_PFX_I;
        w.cur_op  = CUR_PFX_I;
        w.run_add = 1'b1;
        w.seq     = SEQ_LOOP_VC;
        w.target  = PC_PFX_RD;
      end
      PC_SC_SKIP: begin
        w.seq    = SEQ_SKIP_EMPTY;
        w.target = PC_DONE;
      end
      PC_SC_EV: begin
        w.ev_rd = 1'b1;
      end
      PC_SC_RD: begin
        w.cur_op = CUR_RD_V;
      end
      PC_SC_WR: begin
        w.cur_op = CUR_INC_V;
        w.sup_wr = 1'b1;
        w.seq    = SEQ_LOOP_TOT;
        w.target = PC_SC_EV;
      end
      PC_DONE: begin
        w.done = 1'b1;
        w.seq  = SEQ_END;
      end
      default: begin
        w.seq = SEQ_END;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/vei_in_if.sv
interface vei_in_if;
  import vei_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/vei_out_if.sv
interface vei_out_if;
  import vei_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/vertex_to_element_incidence_core.sv
// Vertex-to-element incidence builder (CSR transpose by counting sort).
// in_i carries one beat per item: kind, vertex, position. out_o carries one
// beat (value, error) for each finish and read item; loads give no beat.
// cfg_we_i/cfg_wdata_i write vertex_count; write it only while idle.
// Loads are taken one per cycle while in_i.ready is high. A read item goes
// through the registered read port of the offsets or support memory, then to
// the output register. A finish runs a microcoded program over the offsets,
// cursor, entry and support memories; each counted or scattered entry takes
// three steps through the registered read ports.
// in_i.ready is low while a finish or read is in flight and while the
// output register holds a beat the receiver has not taken; a stalled
// receiver therefore holds off further items but the held beat is kept.
// Reset (rst_ni low, asynchronous) sets vertex_count to 1024, clears the
// entry total, sticky drop flag and finished state. Memories are not
// cleared; offsets are rebuilt by every finish.
module vertex_to_element_incidence_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vei_pkg::VCOUNT_W-1:0]  cfg_wdata_i,
  vei_in_if.sink                        in_i,
  vei_out_if.source                     out_o
);
  import vei_pkg::*;

  // Memories
  logic [VERT_W-1:0]  ev_mem  [MAX_ENTRIES];
  logic [VALUE_W-1:0] off_mem [OFF_DEPTH];
  logic [VALUE_W-1:0] cur_mem [OFF_DEPTH];
  logic [SLOT_W-1:0]  sup_mem [MAX_ENTRIES];

  logic [VERT_W-1:0]  ev_rdata_q;
  logic [VALUE_W-1:0] off_rdata_q;
  logic [VALUE_W-1:0] cur_rdata_q;
  logic [SLOT_W-1:0]  sup_rdata_q;

  // Control state
  logic [VCOUNT_W-1:0] vcount_q;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic                dropped_q, dropped_d;
  logic                finished_q, finished_d;
  logic                busy_q, busy_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [COUNT_W-1:0]  run_q, run_d;
  logic                rd_pend_q, rd_pend_d;
  logic                rd_supp_q, rd_supp_d;
  logic                rd_bad_q, rd_bad_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic [VCOUNT_W-1:0] vc_eff;
  logic                out_free;
  logic                accept;
  ucode_t              uc;
  logic                v_ok;
  logic                loop_vc_more;
  logic                loop_tot_more;
  logic [COUNT_W-1:0]  load_total;

  // Memory port controls
  logic                ev_we, ev_re;
  logic [SLOT_W-1:0]   ev_addr;
  logic                off_we, off_re;
  logic [OFF_AW-1:0]   off_addr;
  logic [VALUE_W-1:0]  off_wdata;
  logic                cur_we, cur_re;
  logic [OFF_AW-1:0]   cur_addr;
  logic [VALUE_W-1:0]  cur_wdata;
  logic                sup_we, sup_re;
  logic [SLOT_W-1:0]   sup_addr;

  assign vc_eff = (vcount_q > VCOUNT_W'(MAX_VERTS)) ? VCOUNT_W'(MAX_VERTS) : vcount_q;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = !busy_q && !rd_pend_q && out_free;
  assign accept      = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Current control word and loop tests
  assign uc            = ucode_rom(pc_q);
  assign v_ok          = {1'b0, ev_rdata_q} < vc_eff;
  assign loop_vc_more  = cnt_q < {{(COUNT_W-VCOUNT_W){1'b0}}, vc_eff};
  assign loop_tot_more = ({1'b0, cnt_q} + (COUNT_W+1)'(1)) < {1'b0, total_q};
  assign load_total    = finished_q ? '0 : total_q;

  // Sequencer and item handling
  always_comb begin
    total_d     = total_q;
    dropped_d   = dropped_q;
    finished_d  = finished_q;
    busy_d      = busy_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    rd_pend_d   = 1'b0;
    rd_supp_d   = rd_supp_q;
    rd_bad_d    = rd_bad_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    ev_we = 1'b0; ev_re = 1'b0; ev_addr = cnt_q[SLOT_W-1:0];
    off_we = 1'b0; off_re = 1'b0; off_addr = cnt_q[OFF_AW-1:0]; off_wdata = '0;
    cur_we = 1'b0; cur_re = 1'b0; cur_addr = cnt_q[OFF_AW-1:0]; cur_wdata = '0;
    sup_we = 1'b0; sup_re = 1'b0; sup_addr = cur_rdata_q[SLOT_W-1:0];

    if (busy_q) begin
      // Datapath actions of the current step
      ev_re = uc.ev_rd;
      case (uc.off_op)
        OFF_CLR_I: begin
          off_we = 1'b1;
        end
        OFF_RD_V: begin
          off_re   = 1'b1;
          off_addr = OFF_AW'(ev_rdata_q);
        end
        OFF_INC_V: begin
          off_we    = v_ok;
          off_addr  = OFF_AW'(ev_rdata_q);
          off_wdata = off_rdata_q + VALUE_W'(1);
        end
        OFF_RD_I: begin
          off_re = 1'b1;
        end
        OFF_PFX_I: begin
          off_we    = 1'b1;
          off_wdata = run_q;
        end
        default: ;
      endcase
      case (uc.cur_op)
        CUR_PFX_I: begin
          cur_we    = 1'b1;
          cur_wdata = run_q;
        end
        CUR_RD_V: begin
          cur_re   = 1'b1;
          cur_addr = OFF_AW'(ev_rdata_q);
        end
        CUR_INC_V: begin
          cur_we    = v_ok;
          cur_addr  = OFF_AW'(ev_rdata_q);
          cur_wdata = cur_rdata_q + VALUE_W'(1);
        end
        default: ;
      endcase
      sup_we = uc.sup_wr && v_ok;
      if (uc.chk_drop && !v_ok) begin
        dropped_d = 1'b1;
      end
      if (uc.run_add) begin
        run_d = run_q + off_rdata_q;
      end
      if (uc.done) begin
        finished_d       = 1'b1;
        out_valid_d      = 1'b1;
        out_data_d.value = run_q;
        out_data_d.error = dropped_q;
      end

      // Next step
      unique case (uc.seq)
        SEQ_NEXT: begin
          pc_d = pc_q + PC_W'(1);
        end
        SEQ_LOOP_VC, SEQ_LOOP_TOT: begin
          if ((uc.seq == SEQ_LOOP_VC) ? loop_vc_more : loop_tot_more) begin
            cnt_d = cnt_q + COUNT_W'(1);
            pc_d  = uc.target;
          end else begin
            cnt_d = '0;
            pc_d  = pc_q + PC_W'(1);
          end
        end
        SEQ_SKIP_EMPTY: begin
          pc_d = (total_q == '0) ? uc.target : pc_q + PC_W'(1);
        end
        SEQ_END: begin
          busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (rd_pend_q) begin
      // Read data from the memory ports goes to the output register
      out_valid_d      = 1'b1;
      out_data_d.value = rd_bad_q ? '0 :
                         rd_supp_q ? {1'b0, sup_rdata_q} : off_rdata_q;
      out_data_d.error = rd_bad_q || dropped_q;
    end else if (accept) begin
      unique case (in_i.data.kind)
        KIND_LOAD: begin
          if (finished_q) begin
            dropped_d  = 1'b0;
            finished_d = 1'b0;
          end
          total_d = load_total;
          if (({1'b0, in_i.data.vertex} >= vc_eff) || (load_total == ENTRY_FULL)) begin
            dropped_d = 1'b1;
          end else begin
            ev_we   = 1'b1;
            ev_addr = load_total[SLOT_W-1:0];
            total_d = load_total + COUNT_W'(1);
          end
        end
        KIND_FINISH: begin
          busy_d = 1'b1;
          pc_d   = PC_CLR;
          cnt_d  = '0;
          run_d  = '0;
        end
        KIND_RD_OFF: begin
          rd_pend_d = 1'b1;
          rd_supp_d = 1'b0;
          rd_bad_d  = !finished_q ||
                      (in_i.data.position > {{(POS_W-VCOUNT_W){1'b0}}, vc_eff});
          off_re    = !rd_bad_d;
          off_addr  = in_i.data.position[OFF_AW-1:0];
        end
        KIND_RD_SUPP: begin
          rd_pend_d = 1'b1;
          rd_supp_d = 1'b1;
          rd_bad_d  = !finished_q || (in_i.data.position >= run_q);
          sup_re    = !rd_bad_d;
          sup_addr  = in_i.data.position[SLOT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= VCOUNT_RESET;
      total_q     <= '0;
      dropped_q   <= 1'b0;
      finished_q  <= 1'b0;
      busy_q      <= 1'b0;
      pc_q        <= PC_CLR;
      cnt_q       <= '0;
      run_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      total_q     <= total_d;
      dropped_q   <= dropped_d;
      finished_q  <= finished_d;
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      run_q       <= run_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_supp_q  <= rd_supp_d;
    rd_bad_q   <= rd_bad_d;
    out_data_q <= out_data_d;
  end

  // Entry vertex store
  always_ff @(posedge clk_i) begin
    if (ev_we) begin
      ev_mem[ev_addr] <= in_i.data.vertex;
    end
    if (ev_re) begin
      ev_rdata_q <= ev_mem[ev_addr];
    end
  end

  // Offsets store
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_addr] <= off_wdata;
    end
    if (off_re) begin
      off_rdata_q <= off_mem[off_addr];
    end
  end

  // Scatter cursors
  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_addr] <= cur_wdata;
    end
    if (cur_re) begin
      cur_rdata_q <= cur_mem[cur_addr];
    end
  end

  // Support list
  always_ff @(posedge clk_i) begin
    if (sup_we) begin
      sup_mem[sup_addr] <= cnt_q[SLOT_W-1:0];
    end
    if (sup_re) begin
      sup_rdata_q <= sup_mem[sup_addr];
    end
  end

endmodule
